>>> rtl/core/hbc_pkg.sv
// Shared opcodes, status codes and code-table layout for the Huffman block coder.
package hbc_pkg;

  localparam logic [1:0] OP_COUNT  = 2'd0;
  localparam logic [1:0] OP_ENCODE = 2'd1;
  localparam logic [1:0] OP_FLUSH  = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_UNKNOWN = 2'd1;
  localparam logic [1:0] ST_TOOLONG = 2'd2;

  // code table entry: {length, bits}, bits right aligned, last code bit in bit 0
  localparam int CODE_BITS = 32;
  localparam int LEN_W     = 6;
  localparam int LEN_CAP   = 63;
  localparam int CODE_W    = LEN_W + CODE_BITS;

  typedef logic [CODE_W-1:0] code_entry_t;

endpackage

>>> rtl/core/hbc_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module hbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/hbc_build.sv
// Tree build sequencer: node memory init, two-minimum merge scans, code walk.
module hbc_build import hbc_pkg::*; #(
  parameter int SYMBOLS    = 256,
  parameter int NODES      = 511,
  parameter int COUNT_BITS = 32,
  localparam int SW = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  done,
  output logic [SW-1:0]         cnt_raddr,
  input  logic [COUNT_BITS-1:0] cnt_rdata,
  output logic                  code_we,
  output logic [SW-1:0]         code_waddr,
  output code_entry_t           code_wdata
);

  localparam int ND  = (NODES > SYMBOLS) ? NODES : SYMBOLS;
  localparam int NAW = (ND > 1) ? $clog2(ND) : 1;
  localparam int PW  = $clog2(ND + 1);
  localparam int RB  = COUNT_BITS + PW;
  localparam int FB  = RB + 1;
  localparam int NB  = RB + 2;
  localparam int EW  = COUNT_BITS + PW + 3;

  localparam logic [PW-1:0] NO_PARENT = PW'(NODES);
  localparam logic [PW-1:0] LAST_SYM  = PW'(SYMBOLS - 1);

  localparam logic [3:0] B_IDLE    = 4'd0;
  localparam logic [3:0] B_INIT_RD = 4'd1;
  localparam logic [3:0] B_INIT_WR = 4'd2;
  localparam logic [3:0] B_MSTART  = 4'd3;
  localparam logic [3:0] B_SCAN_RD = 4'd4;
  localparam logic [3:0] B_SCAN_EV = 4'd5;
  localparam logic [3:0] B_MRG_N   = 4'd6;
  localparam logic [3:0] B_MRG_A   = 4'd7;
  localparam logic [3:0] B_MRG_B   = 4'd8;
  localparam logic [3:0] B_CODE_RD = 4'd9;
  localparam logic [3:0] B_CODE_EV = 4'd10;
  localparam logic [3:0] B_DONE    = 4'd11;

  logic [3:0]            state;
  logic [PW-1:0]         idx, used, b1, b2, walk, len, sym;
  logic [COUNT_BITS-1:0] w1, w2;
  logic                  n1, n2, has1, has2;
  logic [CODE_BITS-1:0]  bits;

  logic                  we;
  logic [NAW-1:0]        waddr, raddr;
  logic [EW-1:0]         wdata, rdata;

  logic [COUNT_BITS-1:0] e_w;
  logic [PW-1:0]         e_par;
  logic                  e_right, e_free, e_nz;
  logic [COUNT_BITS:0]   sum;
  logic [COUNT_BITS-1:0] sum_sat;
  logic [31:0]           len32;
  logic [LEN_W-1:0]      len_sat;

  hbc_ram #(.WIDTH(EW), .DEPTH(ND)) u_nodes (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign e_w     = rdata[COUNT_BITS-1:0];
  assign e_par   = rdata[RB-1:COUNT_BITS];
  assign e_right = rdata[RB];
  assign e_free  = rdata[FB];
  assign e_nz    = rdata[NB];

  assign sum     = {1'b0, w1} + {1'b0, w2};
  assign sum_sat = sum[COUNT_BITS] ? {COUNT_BITS{1'b1}} : sum[COUNT_BITS-1:0];
  assign len32   = 32'(len);
  assign len_sat = (len32 == 32'd0) ? LEN_W'(1) :
                   (len32 > 32'(LEN_CAP)) ? LEN_W'(LEN_CAP) : LEN_W'(len32);

  assign cnt_raddr  = idx[SW-1:0];
  assign code_waddr = sym[SW-1:0];
  assign code_wdata = {len_sat, bits};
  assign done       = (state == B_DONE);

  always_comb begin
    we    = 1'b0;
    waddr = idx[NAW-1:0];
    wdata = '0;
    raddr = idx[NAW-1:0];
    case (state)
      B_INIT_WR: begin
        we    = 1'b1;
        wdata = {cnt_rdata != '0, cnt_rdata != '0, 1'b0, NO_PARENT, cnt_rdata};
      end
      B_MRG_N: begin
        we    = 1'b1;
        waddr = used[NAW-1:0];
        wdata = {1'b0, 1'b1, 1'b0, NO_PARENT, sum_sat};
      end
      B_MRG_A: begin
        we    = 1'b1;
        waddr = b1[NAW-1:0];
        wdata = {n1, 1'b0, 1'b0, used, w1};
      end
      B_MRG_B: begin
        we    = 1'b1;
        waddr = b2[NAW-1:0];
        wdata = {n2, 1'b0, 1'b1, used, w2};
      end
      B_CODE_RD: raddr = walk[NAW-1:0];
      default: ;
    endcase
  end

  always_comb begin
    code_we = 1'b0;
    if (state == B_CODE_EV) begin
      if (!(len == '0 && !e_nz) &&
          !(walk < NO_PARENT && e_par != NO_PARENT && len < NO_PARENT)) begin
        code_we = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      case (state)
        B_IDLE: begin
          if (start) begin
            idx   <= '0;
            state <= B_INIT_RD;
          end
        end
        B_INIT_RD: state <= B_INIT_WR;
        B_INIT_WR: begin
          if (idx == LAST_SYM) begin
            used  <= PW'(SYMBOLS);
            state <= B_MSTART;
          end else begin
            idx   <= idx + 1'b1;
            state <= B_INIT_RD;
          end
        end
        B_MSTART: begin
          has1 <= 1'b0;
          has2 <= 1'b0;
          idx  <= '0;
          if (used < NO_PARENT) begin
            state <= B_SCAN_RD;
          end else begin
            sym   <= '0;
            walk  <= '0;
            len   <= '0;
            bits  <= '0;
            state <= B_CODE_RD;
          end
        end
        B_SCAN_RD: state <= B_SCAN_EV;
        B_SCAN_EV: begin
          // strict compares in ascending order keep the lower index on ties
          if (e_free) begin
            if (!has1 || e_w < w1) begin
              b2 <= b1; w2 <= w1; n2 <= n1; has2 <= has1;
              b1 <= idx; w1 <= e_w; n1 <= e_nz; has1 <= 1'b1;
            end else if (!has2 || e_w < w2) begin
              b2 <= idx; w2 <= e_w; n2 <= e_nz; has2 <= 1'b1;
            end
          end
          if (idx == used - 1'b1) begin
            if (has2 || (e_free && has1)) begin
              state <= B_MRG_N;
            end else begin
              sym   <= '0;
              walk  <= '0;
              len   <= '0;
              bits  <= '0;
              state <= B_CODE_RD;
            end
          end else begin
            idx   <= idx + 1'b1;
            state <= B_SCAN_RD;
          end
        end
        B_MRG_N: state <= B_MRG_A;
        B_MRG_A: state <= B_MRG_B;
        B_MRG_B: begin
          used  <= used + 1'b1;
          state <= B_MSTART;
        end
        B_CODE_RD: state <= B_CODE_EV;
        B_CODE_EV: begin
          if (!(len == '0 && !e_nz) &&
              walk < NO_PARENT && e_par != NO_PARENT && len < NO_PARENT) begin
            if (len32 < 32'(CODE_BITS)) begin
              bits <= bits | (CODE_BITS'(e_right) << len32);
            end
            len   <= len + 1'b1;
            walk  <= e_par;
            state <= B_CODE_RD;
          end else if (sym == LAST_SYM) begin
            state <= B_DONE;
          end else begin
            sym   <= sym + 1'b1;
            walk  <= sym + 1'b1;
            len   <= '0;
            bits  <= '0;
            state <= B_CODE_RD;
          end
        end
        B_DONE:  state <= B_IDLE;
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/core/huffman_block_compressor_core.sv
// Top level of the two-pass static Huffman byte coder.
//
//  channel | signals                          | direction | beat
//  --------+----------------------------------+-----------+---------------------------
//  in      | in_valid in_stall opcode in_byte | sink      | in_valid && !in_stall
//  out     | out_valid out_stall out_byte     | source    | out_valid && !out_stall
//          | status is_last                   |           |
//
//  Items are taken one at a time. COUNT reads the histogram RAM, then writes
//  it back. ENCODE reads the code, then emits each output byte. FLUSH emits
//  any partial byte. The first ENCODE of a block adds the tree build: node
//  init per symbol, then per merge a scan of the node RAM over all used
//  nodes and the node writes, a last scan that finds no pair unless all
//  nodes are used, then each symbol's root walk.
//  Reset and FLUSH clear the histogram through per-symbol valid flops: no
//  clearing pass. in_stall is high whenever an item is in work; a stalled
//  output beat holds the sequencer until the result register drains.
module huffman_block_compressor_core import hbc_pkg::*; #(
  parameter int SYMBOLS      = 256,
  parameter int NODES        = 511,
  parameter int COUNT_BITS   = 32,
  parameter int MAX_CODE_LEN = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] opcode,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic [1:0] status,
  output logic       is_last
);

  localparam int SW = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
  localparam int VW = 7 + CODE_BITS;

  localparam logic [3:0] T_IDLE   = 4'd0;
  localparam logic [3:0] T_CNT_RD = 4'd1;
  localparam logic [3:0] T_CNT_WR = 4'd2;
  localparam logic [3:0] T_BUILD  = 4'd3;
  localparam logic [3:0] T_ENC_RD = 4'd4;
  localparam logic [3:0] T_ENC_EV = 4'd5;
  localparam logic [3:0] T_EMIT   = 4'd6;
  localparam logic [3:0] T_ERR    = 4'd7;
  localparam logic [3:0] T_FLUSH  = 4'd8;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  logic [3:0]            state;
  logic [SW-1:0]         sym_q;
  logic                  sym_ok_q;
  logic                  tree_built;
  logic [6:0]            pend;
  logic [2:0]            pc;
  logic [VW-1:0]         vbuf;
  logic [5:0]            tcnt;
  logic [1:0]            err_q;
  logic [SYMBOLS-1:0]    cnt_vld;
  logic                  vld_q;

  logic                  accept, sym_ok, slot_free, load;
  logic [7:0]            load_byte;
  logic [1:0]            load_status;
  logic                  load_last;

  logic                  cnt_we;
  logic [SW-1:0]         cnt_raddr, b_raddr;
  logic [COUNT_BITS-1:0] cnt_rdata, cnt_eff;

  logic                  b_start, b_done;
  logic                  code_we;
  logic [SW-1:0]         code_waddr;
  code_entry_t           code_wdata, code_rdata;
  logic [LEN_W-1:0]      code_len;
  logic [VW-1:0]         v_new;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state != T_IDLE);
  assign sym_ok    = {1'b0, in_byte} < 9'(SYMBOLS);
  assign slot_free = !out_valid || !out_stall;

  // histogram: a symbol whose valid flop is clear reads as zero
  assign cnt_raddr = (state == T_BUILD) ? b_raddr : sym_q;
  assign cnt_eff   = vld_q ? cnt_rdata : '0;
  assign cnt_we    = (state == T_CNT_WR) && (cnt_eff != COUNT_MAX);

  hbc_ram #(.WIDTH(COUNT_BITS), .DEPTH(SYMBOLS)) u_hist (
    .clk  (clk),
    .we   (cnt_we),
    .waddr(sym_q),
    .wdata(cnt_eff + 1'b1),
    .raddr(cnt_raddr),
    .rdata(cnt_rdata)
  );

  hbc_ram #(.WIDTH(CODE_W), .DEPTH(SYMBOLS)) u_codes (
    .clk  (clk),
    .we   (code_we),
    .waddr(code_waddr),
    .wdata(code_wdata),
    .raddr(sym_q),
    .rdata(code_rdata)
  );

  assign b_start = (state == T_BUILD);

  hbc_build #(.SYMBOLS(SYMBOLS), .NODES(NODES), .COUNT_BITS(COUNT_BITS)) u_build (
    .clk       (clk),
    .rst       (rst),
    .start     (b_start),
    .done      (b_done),
    .cnt_raddr (b_raddr),
    .cnt_rdata (cnt_eff),
    .code_we   (code_we),
    .code_waddr(code_waddr),
    .code_wdata(code_wdata)
  );

  // pending bits followed by the new code, right aligned
  assign code_len = code_rdata[CODE_W-1:CODE_BITS];
  assign v_new    = (VW'(pend) << code_len) | VW'(code_rdata[CODE_BITS-1:0]);

  always_comb begin
    load        = 1'b0;
    load_byte   = '0;
    load_status = ST_OK;
    load_last   = 1'b0;
    case (state)
      T_EMIT: begin
        if (tcnt >= 6'd8 && slot_free) begin
          load      = 1'b1;
          load_byte = 8'(vbuf >> (tcnt - 6'd8));
        end
      end
      T_ERR: begin
        if (slot_free) begin
          load        = 1'b1;
          load_status = err_q;
        end
      end
      T_FLUSH: begin
        if (pc != 3'd0 && slot_free) begin
          load      = 1'b1;
          load_byte = 8'({1'b0, pend} << (4'd8 - {1'b0, pc}));
          load_last = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (load) begin
      out_byte <= load_byte;
      status   <= load_status;
      is_last  <= load_last;
    end
  end

  always_ff @(posedge clk) begin
    vld_q <= cnt_vld[cnt_raddr];
    if (rst) begin
      state      <= T_IDLE;
      tree_built <= 1'b0;
      pend       <= '0;
      pc         <= '0;
      cnt_vld    <= '0;
    end else begin
      case (state)
        T_IDLE: begin
          if (accept) begin
            sym_q    <= in_byte[SW-1:0];
            sym_ok_q <= sym_ok;
            case (opcode)
              OP_COUNT: begin
                if (!tree_built && sym_ok) state <= T_CNT_RD;
              end
              OP_ENCODE: state <= tree_built ? T_ENC_RD : T_BUILD;
              OP_FLUSH:  state <= T_FLUSH;
              default: ;
            endcase
          end
        end
        T_CNT_RD: state <= T_CNT_WR;
        T_CNT_WR: begin
          // saturated counts are left alone
          if (cnt_we) cnt_vld[sym_q] <= 1'b1;
          state <= T_IDLE;
        end
        T_BUILD: begin
          if (b_done) begin
            tree_built <= 1'b1;
            state      <= T_ENC_RD;
          end
        end
        T_ENC_RD: state <= T_ENC_EV;
        T_ENC_EV: begin
          if (!sym_ok_q || cnt_eff == '0) begin
            err_q <= ST_UNKNOWN;
            state <= T_ERR;
          end else if (32'(code_len) > 32'(MAX_CODE_LEN)) begin
            err_q <= ST_TOOLONG;
            state <= T_ERR;
          end else begin
            vbuf  <= v_new;
            tcnt  <= 6'(pc) + 6'(code_len);
            state <= T_EMIT;
          end
        end
        T_EMIT: begin
          if (tcnt >= 6'd8) begin
            if (load) tcnt <= tcnt - 6'd8;
          end else begin
            pend  <= vbuf[6:0] & 7'((8'd1 << tcnt[2:0]) - 8'd1);
            pc    <= tcnt[2:0];
            state <= T_IDLE;
          end
        end
        T_ERR: begin
          if (load) state <= T_IDLE;
        end
        T_FLUSH: begin
          if (pc == 3'd0 || load) begin
            cnt_vld    <= '0;
            tree_built <= 1'b0;
            pend       <= '0;
            pc         <= '0;
            state      <= T_IDLE;
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end

  // no stray pending bits beyond the fill count
  a_pend_clean: assert property (@(posedge clk) disable iff (rst)
    (pc == 3'd0) |-> (pend == 7'd0))
    else $error("pending bits set with empty fill count");

  // build only ever runs on a block without a tree
  a_build_once: assert property (@(posedge clk) disable iff (rst)
    (state == T_BUILD) |-> !tree_built)
    else $error("tree build started on a built block");

  // build completion is seen only while waiting for it
  a_done_wait: assert property (@(posedge clk) disable iff (rst)
    b_done |-> (state == T_BUILD))
    else $error("tree build done outside build wait");

  // an accepted ENCODE item leaves the idle state for the build or the code read
  a_enc_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && opcode == OP_ENCODE) |=> (state == T_BUILD || state == T_ENC_RD))
    else $error("encode beat not taken into work");

endmodule
